>>> rtl/mie_pkg.sv
// Package for the modular inverse block: sequencer states, the status
// bundle between core and top level, and the fixed field width.
// No dependencies.
`default_nettype none
package mie_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_FIX
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic res_valid;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/mie_step_unit.sv
// Shared arithmetic unit: one restoring division step together with one
// shift-add step of the quotient times coefficient product.
// No dependencies.
`default_nettype none
module mie_step_unit #(
  parameter int W = 32,
  parameter int C = 34
) (
  input  logic [W-1:0] rem,
  input  logic         dvd_bit,
  input  logic [W-1:0] divisor,
  input  logic [C-1:0] prod,
  input  logic [C-1:0] coef,
  output logic [W-1:0] rem_next,
  output logic [C-1:0] prod_next
);

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       ge;

  assign shifted   = {rem, dvd_bit};
  assign ge        = shifted >= {1'b0, divisor};
  assign diff      = shifted - {1'b0, divisor};
  assign rem_next  = ge ? diff[W-1:0] : shifted[W-1:0];
  assign prod_next = {prod[C-2:0], 1'b0} + (ge ? coef : {C{1'b0}});

endmodule
`default_nettype wire

>>> rtl/mie_core.sv
// Sequencer and datapath registers of the extended Euclidean algorithm.
// Depends on mie_pkg and mie_step_unit.
`default_nettype none
module mie_core #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [W-1:0]     value,
  input  logic [W-1:0]     modulus,
  input  logic             out_ready,
  output mie_pkg::status_t status,
  output logic [W-1:0]     inverse,
  output logic [W-1:0]     gcd_value
);

  localparam int C  = W + 2;
  localparam int CW = $clog2(W);

  mie_pkg::state_t state, state_next;

  logic [W-1:0]  r0, r1, m, rem, dvd;
  logic [C-1:0]  s0, s1, prod;
  logic [CW-1:0] cnt;
  logic          mod_zero;

  logic [W-1:0]  rem_step;
  logic [C-1:0]  prod_step;
  logic          in_take;

  logic          neg;
  logic [C-1:0]  mag;
  logic [W:0]    red;
  logic [W-1:0]  rmod;

  mie_step_unit #(.W(W), .C(C)) u_step (
    .rem       (rem),
    .dvd_bit   (dvd[W-1]),
    .divisor   (r1),
    .prod      (prod),
    .coef      (s1),
    .rem_next  (rem_step),
    .prod_next (prod_step)
  );

  assign in_take = status.in_ready && in_valid;

  always_comb begin
    state_next = state;
    case (state)
      mie_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (modulus == '0) ? mie_pkg::ST_FIX : mie_pkg::ST_DIV;
        end
      end
      mie_pkg::ST_DIV: begin
        if (cnt == CW'(W - 1)) begin
          state_next = mie_pkg::ST_UPD;
        end
      end
      mie_pkg::ST_UPD: begin
        state_next = (rem == '0) ? mie_pkg::ST_FIX : mie_pkg::ST_DIV;
      end
      mie_pkg::ST_FIX: begin
        if (out_ready) begin
          state_next = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mie_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    status.in_ready  = 1'b0;
    status.res_valid = 1'b0;
    case (state)
      mie_pkg::ST_IDLE: status.in_ready  = 1'b1;
      mie_pkg::ST_FIX:  status.res_valid = 1'b1;
      default: begin
        status.in_ready  = 1'b0;
        status.res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mie_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mie_pkg::ST_IDLE: begin
        if (in_valid) begin
          r0       <= value;
          r1       <= modulus;
          m        <= modulus;
          mod_zero <= modulus == '0;
          s0       <= C'(1);
          s1       <= '0;
          rem      <= '0;
          dvd      <= value;
          prod     <= '0;
          cnt      <= '0;
        end
      end
      mie_pkg::ST_DIV: begin
        rem  <= rem_step;
        prod <= prod_step;
        dvd  <= {dvd[W-2:0], 1'b0};
        cnt  <= cnt + CW'(1);
      end
      mie_pkg::ST_UPD: begin
        r0   <= r1;
        r1   <= rem;
        s0   <= s1;
        s1   <= s0 - prod;
        dvd  <= r1;
        rem  <= '0;
        prod <= '0;
        cnt  <= '0;
      end
      default: begin
      end
    endcase
  end

  // The final coefficient stays below twice the modulus in magnitude, so
  // one conditional subtract reduces it.
  assign neg  = s0[C-1];
  assign mag  = neg ? (C'(0) - s0) : s0;
  assign red  = (mag[W:0] >= {1'b0, m}) ? (mag[W:0] - {1'b0, m}) : mag[W:0];
  assign rmod = red[W-1:0];

  always_comb begin
    if (mod_zero) begin
      inverse = '0;
    end else if (neg) begin
      inverse = (rmod == '0) ? '0 : (m - rmod);
    end else begin
      inverse = rmod;
    end
  end

  assign gcd_value = r0;

  assert property (@(posedge clk) disable iff (rst) in_take |=> !status.in_ready)
    else $error("core stayed ready after taking an item");

  assert property (@(posedge clk) disable iff (rst)
    (state == mie_pkg::ST_DIV) |-> (rem < r1))
    else $error("partial remainder reached the divisor");

  assert property (@(posedge clk) disable iff (rst)
    (state == mie_pkg::ST_DIV) |-> (r1 != '0))
    else $error("division started with a zero divisor");

  assert property (@(posedge clk) disable iff (rst)
    (state == mie_pkg::ST_FIX && !mod_zero) |-> (r0 != '0))
    else $error("gcd is zero for a nonzero modulus");

endmodule
`default_nettype wire

>>> rtl/modular_inverse_ext_euclid.sv
// Each Euclid step is a restoring division in the shared step unit plus one coefficient
// update; after the last step the FIX state normalizes the coefficient and loads the
// output register once the output side can take it. One item is in work at a time;
// tready returns the cycle after the result is loaded. Reset clears the sequencer and
// the output valid flag.
`default_nettype none
module modular_inverse_ext_euclid #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // value [31:0], modulus [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // inverse [31:0], gcd_value [63:32]
);

  localparam int W = OPERAND_WIDTH;
  localparam int F = mie_pkg::FIELD_W;

  mie_pkg::status_t status;

  logic [W-1:0] value_w, modulus_w, inverse_w, gcd_w;
  logic [F-1:0] inverse_f, gcd_f;
  logic         out_ready;

  generate
    if (W < F) begin : g_narrow
      assign value_w   = s_tdata[W-1:0];
      assign modulus_w = s_tdata[F+W-1:F];
      assign inverse_f = {{(F-W){1'b0}}, inverse_w};
      assign gcd_f     = {{(F-W){1'b0}}, gcd_w};
    end else if (W == F) begin : g_equal
      assign value_w   = s_tdata[F-1:0];
      assign modulus_w = s_tdata[2*F-1:F];
      assign inverse_f = inverse_w;
      assign gcd_f     = gcd_w;
    end else begin : g_wide
      assign value_w   = {{(W-F){1'b0}}, s_tdata[F-1:0]};
      assign modulus_w = {{(W-F){1'b0}}, s_tdata[2*F-1:F]};
      assign inverse_f = inverse_w[F-1:0];
      assign gcd_f     = gcd_w[F-1:0];
    end
  endgenerate

  assign out_ready = !m_tvalid || m_tready;
  assign s_tready  = status.in_ready;

  mie_core #(.W(W)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .value     (value_w),
    .modulus   (modulus_w),
    .out_ready (out_ready),
    .status    (status),
    .inverse   (inverse_w),
    .gcd_value (gcd_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= status.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && status.res_valid) begin
      m_tdata <= {gcd_f, inverse_f};
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_modular_inverse_ext_euclid.sv
// Self-checking testbench for modular_inverse_ext_euclid: drives value/modulus pairs
// over the input stream and checks inverse and gcd against an extended Euclid predictor.
// Depends on mie_pkg and the modular_inverse_ext_euclid top level.
module tb_modular_inverse_ext_euclid;
  localparam int FIELD_W = mie_pkg::FIELD_W;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_ITEMS = 370;
  localparam int DRAIN_CYCLES = 1600;
  localparam int LONG_HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [FIELD_W-1:0] gcd_value;
    logic [FIELD_W-1:0] inverse;
  } inverse_result_t;

  class inverse_scoreboard;
    inverse_result_t expected_results[$];
    int mismatches = 0;

    function void note_operands(bit [FIELD_W-1:0] value, bit [FIELD_W-1:0] modulus);
      bit [63:0] r0, r1, s0, s1, q, rn, sn, mag, rem;
      inverse_result_t res;
      if (modulus == 0) begin
        res.inverse = '0;
        res.gcd_value = value;
      end else begin
        r0 = value;
        r1 = modulus;
        s0 = 64'd1;
        s1 = 64'd0;
        while (r1 != 0) begin
          q = r0 / r1;
          rn = r0 - q * r1;
          sn = s0 - q * s1;
          r0 = r1;
          r1 = rn;
          s0 = s1;
          s1 = sn;
        end
        if (s0[63]) begin
          mag = 64'd0 - s0;
          rem = mag % modulus;
          res.inverse = (rem == 0) ? '0 : FIELD_W'(modulus - rem);
        end else begin
          res.inverse = FIELD_W'(s0 % modulus);
        end
        res.gcd_value = FIELD_W'(r0);
      end
      expected_results = {expected_results, res};
    endfunction

    task flag_mismatch(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_inverse(inverse_result_t got);
      inverse_result_t want;
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result", got.inverse, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.inverse !== want.inverse) flag_mismatch("inverse", got.inverse, want.inverse);
        if (got.gcd_value !== want.gcd_value) begin
          flag_mismatch("gcd_value", got.gcd_value, want.gcd_value);
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;  // value [31:0], modulus [63:32]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;       // inverse [31:0], gcd_value [63:32]

  inverse_scoreboard board = new();
  int results_seen = 0;

  modular_inverse_ext_euclid dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Entered and left at a falling edge; holds tvalid low for the gap first.
  task automatic send_operands(input logic [FIELD_W-1:0] value,
                               input logic [FIELD_W-1:0] modulus, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {modulus, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_operands(value, modulus);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (board.expected_results.size() != 0);
  endtask

  initial begin
    int gap;
    logic [63:0] directed[$];
    logic [FIELD_W-1:0] value, modulus, factor, span, fa, fb, ft;
    directed = '{
      {32'd7, 32'd0}, {32'hFFFFFFFF, 32'd0}, {32'd1, 32'd5}, {32'd1, 32'hFFFFFFFF},
      {32'd1, 32'd0}, {32'd1, 32'd1}, {32'hFFFFFFFF, 32'hFFFFFFFF}, {32'd7, 32'd3},
      {32'd7, 32'd10}, {32'hFFFFFFFE, 32'hFFFFFFFF}, {32'hFFFFFFFF, 32'd2},
      {32'd9, 32'd6}, {32'h80000000, 32'd1}, {32'hFFFFFFFF, 32'h80000000},
      {32'hFFFFFFFB, 32'h9E3779B9}, {32'd1836311903, 32'd2971215073},
      {32'd2971215073, 32'd1836311903}, {32'h12345678, 32'h12345678},
      {32'h55555555, 32'hAAAAAAAA}, {32'hAAAAAAAB, 32'h55555555}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) begin
      send_operands(directed[i][31:0], directed[i][63:32], $urandom_range(0, 13));
    end
    wait_all_results();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 5))
        0: begin
          value = $urandom;
          modulus = $urandom;
          if (modulus == 0) modulus = 1;
        end
        1: begin
          value = $urandom;
          modulus = $urandom_range(1, 300);
        end
        2: begin
          modulus = $urandom | 32'd1;
          value = $urandom % modulus;
        end
        3: begin
          factor = $urandom_range(2, 1000);
          span = 32'hFFFFFFFF / factor;
          modulus = factor * $urandom_range(1, span);
          value = factor * $urandom_range(0, span);
        end
        4: begin
          fa = 1;
          fb = 1;
          repeat ($urandom_range(1, 45)) begin
            ft = fa + fb;
            fa = fb;
            fb = ft;
          end
          if ($urandom_range(0, 1) == 0) begin
            value = fb;
            modulus = fa;
          end else begin
            value = fa;
            modulus = fb;
          end
        end
        default: begin
          modulus = $urandom_range(1, 65535);
          value = modulus * $urandom_range(0, 65535);
        end
      endcase
      gap = (n >= 250 && n < 290) ? 0 : $urandom_range(0, 13);
      send_operands(value, modulus, gap);
      if (n == 180) wait_all_results();
    end
    s_tvalid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // The long hold-off lets the block fill up and stall its input.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_seen == 60) gap = LONG_HOLD_CYCLES;
      else if (results_seen >= 300 && results_seen < 340) gap = 0;
      else gap = $urandom_range(0, 13);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.check_inverse(m_tdata);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> modular_inverse_ext_euclid.f
rtl/mie_pkg.sv
rtl/mie_step_unit.sv
rtl/mie_core.sv
rtl/modular_inverse_ext_euclid.sv
tb/tb_modular_inverse_ext_euclid.sv
